>>> src/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types, constants, microcode store and address helpers for the Sv32
// page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned VA_W     = 32;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ROOT_W   = 22;

  localparam logic [DATA_W-1:0] ENTRY_VALID    = 32'h0000_0001;
  localparam logic [DATA_W-1:0] ENTRY_ACCESSED = 32'h0000_0040;
  localparam logic [DATA_W-1:0] ENTRY_DIRTY    = 32'h0000_0080;

  typedef logic [MEM_AW-1:0] slot_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_XLATE_RD = 2'd0,
    MODE_XLATE_WR = 2'd1,
    MODE_STORE    = 2'd2,
    MODE_LOAD     = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK            = 2'd0,
    STATUS_FIRST_INVALID = 2'd1,
    STATUS_LEAF_INVALID  = 2'd2
  } status_e;

  // Microprogram step addresses
  typedef enum logic [3:0] {
    STEP_CLEAR  = 4'd0,
    STEP_IDLE   = 4'd1,
    STEP_WALK   = 4'd2,
    STEP_CHECK  = 4'd3,
    STEP_UPDATE = 4'd4,
    STEP_FLT1   = 4'd5,
    STEP_FLT2   = 4'd6,
    STEP_STORE  = 4'd7,
    STEP_LOAD   = 4'd8
  } step_e;

  typedef enum logic [2:0] {
    ADDR_CLEAR,
    ADDR_PORT,
    ADDR_WALK,
    ADDR_LEAF_Q,
    ADDR_WIDX_Q
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_ZERO,
    WD_ITEM,
    WD_LEAF_SET
  } wd_sel_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_PA,
    RES_FIRST_BAD,
    RES_LEAF_BAD,
    RES_ZERO,
    RES_RDATA
  } res_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_CLR_BUSY,
    C_DISPATCH,
    C_ENTRY_BAD
  } cond_e;

  typedef struct packed {
    logic      in_ready;
    logic      capture_leaf;
    logic      clr_inc;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    res_e      res;
    cond_e     cond;
    step_e     target;
  } ctl_t;

  typedef struct packed {
    logic  clr_last;
    logic  entry_bad;
    logic  in_fire;
    logic  stall;
    mode_e in_mode;
  } flags_t;

  localparam ctl_t CTL_NOP = '{
    in_ready:     1'b0,
    capture_leaf: 1'b0,
    clr_inc:      1'b0,
    mem_rd:       1'b0,
    mem_wr:       1'b0,
    addr_sel:     ADDR_PORT,
    wd_sel:       WD_ZERO,
    res:          RES_NONE,
    cond:         C_NEXT,
    target:       STEP_IDLE
  };

  // Control store: one word per step
  function automatic ctl_t ucode_rom(step_e step);
    ctl_t c;
    c = CTL_NOP;
    unique case (step)
      STEP_CLEAR: begin
        c.addr_sel = ADDR_CLEAR;
        c.mem_wr   = 1'b1;
        c.wd_sel   = WD_ZERO;
        c.clr_inc  = 1'b1;
        c.cond     = C_CLR_BUSY;
        c.target   = STEP_CLEAR;
      end
      STEP_IDLE: begin
        c.in_ready = 1'b1;
        c.addr_sel = ADDR_PORT;
        c.mem_rd   = 1'b1;
        c.cond     = C_DISPATCH;
        c.target   = STEP_IDLE;
      end
      STEP_WALK: begin
        c.addr_sel     = ADDR_WALK;
        c.mem_rd       = 1'b1;
        c.capture_leaf = 1'b1;
        c.cond         = C_ENTRY_BAD;
        c.target       = STEP_FLT1;
      end
      STEP_CHECK: begin
        c.cond   = C_ENTRY_BAD;
        c.target = STEP_FLT2;
      end
      STEP_UPDATE: begin
        c.addr_sel = ADDR_LEAF_Q;
        c.mem_wr   = 1'b1;
        c.wd_sel   = WD_LEAF_SET;
        c.res      = RES_PA;
        c.cond     = C_JUMP;
        c.target   = STEP_IDLE;
      end
      STEP_FLT1: begin
        c.res    = RES_FIRST_BAD;
        c.cond   = C_JUMP;
        c.target = STEP_IDLE;
      end
      STEP_FLT2: begin
        c.res    = RES_LEAF_BAD;
        c.cond   = C_JUMP;
        c.target = STEP_IDLE;
      end
      STEP_STORE: begin
        c.addr_sel = ADDR_WIDX_Q;
        c.mem_wr   = 1'b1;
        c.wd_sel   = WD_ITEM;
        c.res      = RES_ZERO;
        c.cond     = C_JUMP;
        c.target   = STEP_IDLE;
      end
      STEP_LOAD: begin
        c.res    = RES_RDATA;
        c.cond   = C_JUMP;
        c.target = STEP_IDLE;
      end
      default: begin
        c.cond   = C_JUMP;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

  // Mapping of an accepted item's mode to its first step
  function automatic step_e dispatch(mode_e mode);
    step_e s;
    unique case (mode)
      MODE_STORE: s = STEP_STORE;
      MODE_LOAD:  s = STEP_LOAD;
      default:    s = STEP_WALK;
    endcase
    return s;
  endfunction

  function automatic slot_t byte_slot(logic [VA_W-1:0] byte_addr);
    return byte_addr[MEM_AW+1:2];
  endfunction

  function automatic slot_t word_slot(logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[MEM_AW-1:0];
  endfunction

  // root << 12 | VPN[1] << 2, kept to 32 bits
  function automatic logic [VA_W-1:0] first_addr(logic [ROOT_W-1:0] root,
                                                 logic [VA_W-1:0] va);
    return {root[19:0], va[31:22], 2'b00};
  endfunction

  // PPN(entry) << 12 | VPN[0] << 2, kept to 32 bits
  function automatic logic [VA_W-1:0] leaf_addr(logic [DATA_W-1:0] entry,
                                                logic [VA_W-1:0] va);
    return {entry[29:10], va[21:12], 2'b00};
  endfunction

  function automatic logic [VA_W-1:0] phys_of(logic [DATA_W-1:0] entry,
                                              logic [VA_W-1:0] va);
    return {entry[29:10], va[11:0]};
  endfunction

endpackage

>>> src/ptw_if.sv
// ----------------------------------------------------------------------------
// ptw_if
// Valid/ready channels of the page-table walker: request, response and
// root-table configuration.
// ----------------------------------------------------------------------------
interface ptw_req_if;
  import ptw_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [VA_W-1:0]     virt_addr;
  logic [IDX_W-1:0]    phys_word_index;
  logic [DATA_W-1:0]   write_data;

  modport source (output valid, mode, virt_addr, phys_word_index, write_data,
                  input ready);
  modport sink   (input valid, mode, virt_addr, phys_word_index, write_data,
                  output ready);
endinterface

interface ptw_rsp_if;
  import ptw_pkg::*;
  logic                valid;
  logic                ready;
  logic [VA_W-1:0]     phys_addr;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_data;

  modport source (output valid, phys_addr, status, read_data, input ready);
  modport sink   (input valid, phys_addr, status, read_data, output ready);
endinterface

interface ptw_cfg_if;
  import ptw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root_table_ppn;

  modport source (output valid, root_table_ppn, input ready);
  modport sink   (input valid, root_table_ppn, output ready);
endinterface

>>> src/ptw_ram.sv
// ----------------------------------------------------------------------------
// ptw_ram
// Single-port RAM, one access per cycle, registered read data that holds
// when no read is issued.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ptw_seq.sv
// ----------------------------------------------------------------------------
// ptw_seq
// Microcode sequencer: step counter, control store lookup and next-step
// selection with conditional jumps and mode dispatch.
// ----------------------------------------------------------------------------
module ptw_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptw_pkg::flags_t flags_i,
  output ptw_pkg::ctl_t   ctl_o
);
  import ptw_pkg::*;

  step_e upc_q, upc_d;
  ctl_t  ctl;

  assign ctl   = ucode_rom(upc_q);
  assign ctl_o = ctl;

  always_comb begin
    upc_d = step_e'(upc_q + 1'b1);
    if (flags_i.stall) begin
      upc_d = upc_q;
    end else begin
      unique case (ctl.cond)
        C_NEXT:      upc_d = step_e'(upc_q + 1'b1);
        C_JUMP:      upc_d = ctl.target;
        C_CLR_BUSY:  upc_d = flags_i.clr_last ? step_e'(upc_q + 1'b1) : ctl.target;
        C_DISPATCH:  upc_d = flags_i.in_fire ? dispatch(flags_i.in_mode) : ctl.target;
        C_ENTRY_BAD: upc_d = flags_i.entry_bad ? ctl.target : step_e'(upc_q + 1'b1);
        default:     upc_d = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_CLEAR;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> src/ptw_dp.sv
// ----------------------------------------------------------------------------
// ptw_dp
// Walker datapath: item and root registers, address and write-data
// selection, page-table memory, clear counter and response register.
// ----------------------------------------------------------------------------
module ptw_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptw_pkg::ctl_t    ctl_i,
  output ptw_pkg::flags_t  flags_o,
  ptw_req_if.sink          req,
  ptw_rsp_if.source        rsp,
  ptw_cfg_if.sink          cfg
);
  import ptw_pkg::*;

  logic [ROOT_W-1:0] root_q;
  slot_t             clr_cnt_q;
  mode_e             mode_q;
  logic [VA_W-1:0]   va_q;
  logic [IDX_W-1:0]  widx_q;
  logic [DATA_W-1:0] wdata_q;
  slot_t             leaf_slot_q;

  logic              out_valid_q, out_valid_d;
  logic [VA_W-1:0]   out_pa_q, out_pa_d;
  status_e           out_status_q, out_status_d;
  logic [DATA_W-1:0] out_rdata_q, out_rdata_d;

  logic              in_fire;
  logic              stall;
  logic              out_load;
  slot_t             port_slot;
  slot_t             walk_slot;
  slot_t             mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] set_bits;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg.valid) begin
      root_q <= cfg.root_table_ppn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctl_i.clr_inc) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign in_fire   = req.valid && ctl_i.in_ready;
  assign req.ready = ctl_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q  <= mode_e'(req.mode);
      va_q    <= req.virt_addr;
      widx_q  <= req.phys_word_index;
      wdata_q <= req.write_data;
    end
  end

  // A result step waits while the response register is still full
  assign stall    = (ctl_i.res != RES_NONE) && out_valid_q && !rsp.ready;
  assign out_load = (ctl_i.res != RES_NONE) && !stall;

  assign port_slot = (mode_e'(req.mode) == MODE_LOAD) ? word_slot(req.phys_word_index)
                                                       : byte_slot(first_addr(root_q,
                                                                              req.virt_addr));
  assign walk_slot = byte_slot(leaf_addr(mem_rdata, va_q));

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture_leaf) begin
      leaf_slot_q <= walk_slot;
    end
  end

  always_comb begin
    unique case (ctl_i.addr_sel)
      ADDR_CLEAR:  mem_addr = clr_cnt_q;
      ADDR_PORT:   mem_addr = port_slot;
      ADDR_WALK:   mem_addr = walk_slot;
      ADDR_LEAF_Q: mem_addr = leaf_slot_q;
      ADDR_WIDX_Q: mem_addr = word_slot(widx_q);
      default:     mem_addr = port_slot;
    endcase
  end

  assign set_bits = (mode_q == MODE_XLATE_WR) ? (ENTRY_ACCESSED | ENTRY_DIRTY)
                                              : ENTRY_ACCESSED;

  always_comb begin
    unique case (ctl_i.wd_sel)
      WD_ZERO:     mem_wdata = '0;
      WD_ITEM:     mem_wdata = wdata_q;
      WD_LEAF_SET: mem_wdata = mem_rdata | set_bits;
      default:     mem_wdata = '0;
    endcase
  end

  ptw_ram #(
    .Depth (MEM_WORDS),
    .Width (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.mem_wr && !stall),
    .re_i    (ctl_i.mem_rd && !stall),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign flags_o.clr_last  = (clr_cnt_q == slot_t'(MEM_WORDS - 1));
  assign flags_o.entry_bad = ((mem_rdata & ENTRY_VALID) == '0);
  assign flags_o.in_fire   = in_fire;
  assign flags_o.stall     = stall;
  assign flags_o.in_mode   = mode_e'(req.mode);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_pa_d     = '0;
    out_status_d = STATUS_OK;
    out_rdata_d  = '0;
    case (ctl_i.res)
      RES_PA:        out_pa_d     = phys_of(mem_rdata, va_q);
      RES_FIRST_BAD: out_status_d = STATUS_FIRST_INVALID;
      RES_LEAF_BAD:  out_status_d = STATUS_LEAF_INVALID;
      RES_RDATA:     out_rdata_d  = mem_rdata;
      default:       out_rdata_d  = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pa_q     <= out_pa_d;
      out_status_q <= out_status_d;
      out_rdata_q  <= out_rdata_d;
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.phys_addr = out_pa_q;
  assign rsp.status    = out_status_q;
  assign rsp.read_data = out_rdata_q;

endmodule

>>> src/sv32_page_table_walker_top.sv
// ----------------------------------------------------------------------------
// sv32_page_table_walker_top
// Two-level Sv32 page-table walker over an internal page-table memory.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one transfer per item: mode, virt_addr, phys_word_index,
//          write_data. Modes: translate read, translate write (sets A, or A
//          and D, in the leaf), store word, load word.
//   rsp  : one transfer per item: phys_addr, status, read_data.
//   cfg  : root_table_ppn; write only while no item is in flight.
// Reset clears the root register and starts a clearing pass that zeroes
// all MEM_WORDS (4096) memory words, one per cycle; req is not ready during
// the clearing pass, cfg is.
// From accept, a translation runs first-level read, leaf read, check and
// leaf write-back, leaving early to a fault step; store and load go straight
// to their result step. The next item is accepted in the cycle after the
// response is loaded. The control program runs one step per cycle unless a
// result step stalls, each with at most one access to the single-port memory.
// A stalled rsp holds the response; the walker then parks on its next
// result step until the response register is free.
// ----------------------------------------------------------------------------
module sv32_page_table_walker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptw_req_if.sink    req_i,
  ptw_rsp_if.source  rsp_o,
  ptw_cfg_if.sink    cfg_i
);
  import ptw_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  ptw_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  ptw_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .flags_o (flags),
    .req     (req_i),
    .rsp     (rsp_o),
    .cfg     (cfg_i)
  );

endmodule
